[rtl/vmu_pkg.sv]
// Shared types, widths and a helper function of the vector math unit.
`timescale 1ns / 1ps

package vmu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int DW         = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int PROD_W     = 2 * DW;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DIVD_W     = DW + FRAC_BITS;
   localparam int QUOT_W     = FRAC_BITS + 1;
   localparam int SQRT_STEPS = DW;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int THR_W      = 31;

   typedef enum logic [2:0] {
      CMD_NORM      = 3'd0,
      CMD_NORMALIZE = 3'd1,
      CMD_DOT       = 3'd2,
      CMD_CROSS     = 3'd3,
      CMD_SCALE     = 3'd4,
      CMD_ZERO      = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0]           command;
      logic signed [DW-1:0] a_x;
      logic signed [DW-1:0] a_y;
      logic signed [DW-1:0] a_z;
      logic signed [DW-1:0] b_x;
      logic signed [DW-1:0] b_y;
      logic signed [DW-1:0] b_z;
      logic signed [DW-1:0] factor;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] r_x;
      logic signed [DW-1:0] r_y;
      logic signed [DW-1:0] r_z;
      logic signed [DW-1:0] scalar_out;
      logic                 too_small;
      logic                 is_zero;
      logic                 saturated;
   } rsp_type;

   // Operands handed to one lane: its own component and two product pairs.
   typedef struct packed {
      logic signed [DW-1:0] comp;
      logic signed [DW-1:0] p0a;
      logic signed [DW-1:0] p0b;
      logic signed [DW-1:0] p1a;
      logic signed [DW-1:0] p1b;
   } lane_op_type;

   typedef struct packed {
      logic [PROD_W-1:0]        sq;
      logic signed [PROD_W-1:0] m0;
      logic signed [PROD_W-1:0] m1;
   } lane_prod_type;

   function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
      mag = v[DW-1] ? (~v + DW'(1)) : v;
   endfunction

endpackage

[rtl/vmu_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module vmu_sqrt
   import vmu_pkg::*;
(
   input  logic              clock,
   input  logic [PROD_W-1:0] radicand,
   output logic [DW-1:0]     root
);

   logic [PROD_W-1:0] x_ff   [SQRT_STEPS];
   logic [PROD_W-1:0] res_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (PROD_W - 2 - 2 * k);
      logic [PROD_W-1:0] src_x;
      logic [PROD_W-1:0] src_r;
      logic [PROD_W-1:0] trial;

      if (k == 0) begin : g_first
         assign src_x = radicand;
         assign src_r = '0;
      end else begin : g_next
         assign src_x = x_ff[k-1];
         assign src_r = res_ff[k-1];
      end

      assign trial = src_r + BIT;

      always_ff @(posedge clock) begin
         if (src_x >= trial) begin
            x_ff[k]   <= src_x - trial;
            res_ff[k] <= (src_r >> 1) + BIT;
         end else begin
            x_ff[k]   <= src_x;
            res_ff[k] <= src_r >> 1;
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][DW-1:0];

endmodule

[rtl/vmu_lane.sv]
// One component lane: its multipliers and its pipelined normalize divider.
`timescale 1ns / 1ps

module vmu_lane
   import vmu_pkg::*;
(
   input  logic                 clock,
   input  lane_op_type          op,
   output lane_prod_type        prod,
   input  logic signed [DW-1:0] div_a,
   input  logic [DW-1:0]        norm,
   output logic signed [DW-1:0] quotient
);

   lane_prod_type prod_ff;
   logic [DW-1:0] comp_mag;

   assign comp_mag = mag(op.comp);

   always_ff @(posedge clock) begin
      prod_ff.sq <= PROD_W'(comp_mag) * PROD_W'(comp_mag);
      prod_ff.m0 <= op.p0a * op.p0b;
      prod_ff.m1 <= op.p1a * op.p1b;
   end

   assign prod = prod_ff;

   // Restoring division; the quotient never exceeds one, so FRAC_BITS+1 bits suffice.
   logic [DIVD_W-1:0] rem_ff [DIV_STEPS];
   logic [QUOT_W-1:0] quo_ff [DIV_STEPS];
   logic [DW-1:0]     den_ff [DIV_STEPS];
   logic              neg_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int SH = QUOT_W - 1 - k;
      logic [DIVD_W-1:0] src_rem;
      logic [QUOT_W-1:0] src_quo;
      logic [DW-1:0]     src_den;
      logic              src_neg;
      logic [DIVD_W-1:0] trial;

      if (k == 0) begin : g_first
         assign src_rem = {mag(div_a), FRAC_BITS'(0)};
         assign src_quo = '0;
         assign src_den = norm;
         assign src_neg = div_a[DW-1];
      end else begin : g_next
         assign src_rem = rem_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_neg = neg_ff[k-1];
      end

      assign trial = DIVD_W'(src_den) << SH;

      always_ff @(posedge clock) begin
         den_ff[k] <= src_den;
         neg_ff[k] <= src_neg;
         if (src_rem >= trial) begin
            rem_ff[k] <= src_rem - trial;
            quo_ff[k] <= src_quo | (QUOT_W'(1) << SH);
         end else begin
            rem_ff[k] <= src_rem;
            quo_ff[k] <= src_quo;
         end
      end
   end

   logic [DW-1:0] q_ext;
   assign q_ext    = DW'(quo_ff[DIV_STEPS-1]);
   assign quotient = neg_ff[DIV_STEPS-1] ? (~q_ext + DW'(1)) : q_ext;

endmodule

[rtl/vector3_math_unit_top.sv]
// Top level of the three-component Q16.16 vector math unit.
`timescale 1ns / 1ps

// Usage:
// An item is a command, vectors a and b and a scalar factor in req_payload. It
// is taken at a rising edge where start is high and busy is low; busy is always
// low, so a new item may be transferred in every cycle.
// Every item gives exactly one result. rsp_strobe is high for one cycle with
// rsp_payload, and the results leave in input order. Throughput is one item
// per cycle. An item passes through the input, multiply and sum registers,
// the square root pipeline (32 stages, one root bit each), the normalize
// divider in each lane (17 stages, one quotient bit each) and the output
// register.
// The receiver cannot stall: a result is valid in its strobe cycle only.
// The threshold register is written through csr_write_en and csr_write_data
// and should change only while no item is in flight.
// Synchronous reset empties the pipeline (no strobes follow from items taken
// before it) and sets the threshold to 7.
module vector3_math_unit_top
   import vmu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_strobe,
   output rsp_type          rsp_payload,
   input  logic             csr_write_en,
   input  logic [THR_W-1:0] csr_write_data
);

   localparam int LATENCY = SQRT_STEPS + DIV_STEPS + 4;
   localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic                valid;
      logic [2:0]          command;
      logic [2:0][DW-1:0]  a;
      logic [2:0][DW-1:0]  r;
      logic [DW-1:0]       sc;
      logic                too_small;
      logic                zero;
      logic                sat;
   } ctx_type;

   typedef struct packed {
      logic [DW-1:0] value;
      logic          clip;
   } sat_type;

   function automatic sat_type sat_word(input logic signed [SUM_W-1:0] v);
      sat_type s;
      s.clip  = 1'b0;
      s.value = v[DW-1:0];
      if (v > $signed(SUM_W'(WORD_MAX))) begin
         s.value = WORD_MAX;
         s.clip  = 1'b1;
      end else if (v < -$signed(SUM_W'(WORD_MAX)) - SUM_W'(1)) begin
         s.value = WORD_MIN;
         s.clip  = 1'b1;
      end
      return s;
   endfunction

   assign busy = 1'b0;

   // Threshold register.
   logic [THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(7);
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   // Input register.
   logic    v0_ff;
   req_type in_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end
   always_ff @(posedge clock) begin
      in_ff <= req_payload;
   end

   // Operand routing: each lane gets the products its command needs.
   logic signed [DW-1:0] av [3];
   logic signed [DW-1:0] bv [3];
   lane_op_type          lane_op [3];
   assign av[0] = in_ff.a_x;
   assign av[1] = in_ff.a_y;
   assign av[2] = in_ff.a_z;
   assign bv[0] = in_ff.b_x;
   assign bv[1] = in_ff.b_y;
   assign bv[2] = in_ff.b_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane_op[i].comp = av[i];
         unique case (in_ff.command)
            CMD_CROSS: begin
               lane_op[i].p0a = av[(i+1)%3];
               lane_op[i].p0b = bv[(i+2)%3];
               lane_op[i].p1a = av[(i+2)%3];
               lane_op[i].p1b = bv[(i+1)%3];
            end
            CMD_SCALE: begin
               lane_op[i].p0a = in_ff.factor;
               lane_op[i].p0b = av[i];
               lane_op[i].p1a = '0;
               lane_op[i].p1b = '0;
            end
            default: begin
               lane_op[i].p0a = av[i];
               lane_op[i].p0b = bv[i];
               lane_op[i].p1a = '0;
               lane_op[i].p1b = '0;
            end
         endcase
      end
   end

   lane_prod_type        prod [3];
   logic signed [DW-1:0] quot [3];
   logic [DW-1:0]        norm;
   ctx_type              ctx_n;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vmu_lane u_lane (
         .clock    (clock),
         .op       (lane_op[i]),
         .prod     (prod[i]),
         .div_a    (ctx_n.a[i]),
         .norm     (norm),
         .quotient (quot[i])
      );
   end

   // Stage 1 context, with the zero test.
   ctx_type ctx1_ff;
   ctx_type ctx1_in;
   always_comb begin
      ctx1_in         = '0;
      ctx1_in.valid   = v0_ff;
      ctx1_in.command = in_ff.command;
      for (int i = 0; i < 3; i++) begin
         ctx1_in.a[i] = av[i];
      end
      ctx1_in.zero = (in_ff.command == CMD_ZERO) &&
                     (mag(av[0]) < DW'(thr_ff)) && (mag(av[1]) < DW'(thr_ff)) &&
                     (mag(av[2]) < DW'(thr_ff));
   end

   // Stage 2: sum of squares, and the dot, cross and scale results.
   ctx_type           ctx2_ff;
   ctx_type           ctx2_in;
   logic [PROD_W-1:0] sumsq_ff;
   logic [PROD_W-1:0] sumsq_in;
   sat_type           s_dot;
   sat_type           s_cross [3];
   sat_type           s_scale [3];
   always_comb begin
      sumsq_in = prod[0].sq + prod[1].sq + prod[2].sq;
      s_dot = sat_word((SUM_W'(prod[0].m0) + SUM_W'(prod[1].m0) + SUM_W'(prod[2].m0))
                       >>> FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         s_cross[i] = sat_word((SUM_W'(prod[i].m0) - SUM_W'(prod[i].m1)) >>> FRAC_BITS);
         s_scale[i] = sat_word(SUM_W'(prod[i].m0) >>> FRAC_BITS);
      end
      ctx2_in = ctx1_ff;
      unique case (ctx1_ff.command)
         CMD_DOT: begin
            ctx2_in.sc  = s_dot.value;
            ctx2_in.sat = s_dot.clip;
         end
         CMD_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               ctx2_in.r[i] = s_cross[i].value;
            end
            ctx2_in.sat = s_cross[0].clip | s_cross[1].clip | s_cross[2].clip;
         end
         CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               ctx2_in.r[i] = s_scale[i].value;
            end
            ctx2_in.sat = s_scale[0].clip | s_scale[1].clip | s_scale[2].clip;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx1_ff.valid <= 1'b0;
         ctx2_ff.valid <= 1'b0;
      end else begin
         ctx1_ff <= ctx1_in;
         ctx2_ff <= ctx2_in;
      end
   end
   always_ff @(posedge clock) begin
      sumsq_ff <= sumsq_in;
   end

   vmu_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sumsq_ff),
      .root     (norm)
   );

   // Context rides alongside the root pipeline.
   ctx_type mid_ff [SQRT_STEPS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            mid_ff[k].valid <= 1'b0;
         end
      end else begin
         mid_ff[0] <= ctx2_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
      end
   end

   // With the root known: the norm result and the small-norm decision.
   always_comb begin
      ctx_n = mid_ff[SQRT_STEPS-1];
      if (ctx_n.command == CMD_NORM) begin
         ctx_n.sc  = norm[DW-1] ? WORD_MAX : norm;
         ctx_n.sat = norm[DW-1];
      end
      ctx_n.too_small = (ctx_n.command == CMD_NORMALIZE) &&
                        ((norm < {1'b0, thr_ff}) || (norm == '0));
   end

   // Context rides alongside the lane dividers.
   ctx_type tail_ff [DIV_STEPS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            tail_ff[k].valid <= 1'b0;
         end
      end else begin
         tail_ff[0] <= ctx_n;
         for (int k = 1; k < DIV_STEPS; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
      end
   end

   // Merge: pick the normalized vector, the pass-through or the early results.
   ctx_type fin;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    strobe_ff;
   always_comb begin
      fin = tail_ff[DIV_STEPS-1];
      rsp_in.r_x        = fin.r[0];
      rsp_in.r_y        = fin.r[1];
      rsp_in.r_z        = fin.r[2];
      rsp_in.scalar_out = fin.sc;
      rsp_in.too_small  = fin.too_small;
      rsp_in.is_zero    = fin.zero;
      rsp_in.saturated  = fin.sat;
      if (fin.command == CMD_NORMALIZE) begin
         if (fin.too_small) begin
            rsp_in.r_x = fin.a[0];
            rsp_in.r_y = fin.a[1];
            rsp_in.r_z = fin.a[2];
         end else begin
            rsp_in.r_x = quot[0];
            rsp_in.r_y = quot[1];
            rsp_in.r_z = quot[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fin.valid;
      end
   end
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result at the expected cycle");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_payload.too_small && rsp_payload.is_zero))
      else $error("too_small and is_zero raised together");

   a_small_unclipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.too_small) |-> !rsp_payload.saturated)
      else $error("pass-through result flagged as saturated");

   a_zero_test_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.is_zero) |->
      (rsp_payload.r_x == '0 && rsp_payload.r_y == '0 && rsp_payload.r_z == '0 &&
       rsp_payload.scalar_out == '0))
      else $error("zero test result carries nonzero values");
`endif

endmodule
